// ===== design/fvt_pkg.sv =====
// Shared types and constants for the frustum visibility test block.
package fvt_pkg;

   localparam int PlaneRegs  = 6;
   localparam int IdxWidth   = 3;
   localparam int AddrWidth  = IdxWidth + 3;
   localparam int DataWidth  = 64;
   localparam int ScaleShift = 14;
   localparam int SumWidth   = 35;

   // register indexes
   localparam logic [IdxWidth-1:0] RegBias = 3'd6;

   typedef logic signed [15:0]         fix_type;
   typedef logic [14:0]                radius_type;
   typedef logic signed [31:0]         prod_type;
   typedef logic signed [16:0]         ofs_type;
   typedef logic signed [SumWidth-1:0] sum_type;
   typedef logic [IdxWidth-1:0]        idx_type;
   typedef logic [DataWidth-1:0]       data_type;

   typedef struct packed {
      fix_type offset;
      fix_type nz;
      fix_type ny;
      fix_type nx;
   } plane_type;

endpackage

// ===== design/fvt_req_if.sv =====
// Vertex input channel: valid/ready handshake with position, radius and end mark.
interface fvt_req_if;
   import fvt_pkg::*;

   logic       valid;
   logic       ready;
   fix_type    pos_x;
   fix_type    pos_y;
   fix_type    pos_z;
   radius_type radius;
   logic       last_vertex;

   modport source (output valid, pos_x, pos_y, pos_z, radius, last_vertex, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, radius, last_vertex, output ready);
endinterface

// ===== design/fvt_rsp_if.sv =====
// Visibility result channel: valid/ready handshake with the visible flag.
interface fvt_rsp_if;
   logic valid;
   logic ready;
   logic visible;

   modport source (output valid, visible, input ready);
   modport sink   (input valid, visible, output ready);
endinterface

// ===== design/fvt_csr.sv =====
// APB-style register file holding the plane equations and the cull bias.
module fvt_csr (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [fvt_pkg::AddrWidth-1:0] paddr,
   input  fvt_pkg::data_type         pwdata,
   output fvt_pkg::data_type         prdata,
   output logic                      pready,
   output fvt_pkg::plane_type        plane_o [fvt_pkg::PlaneRegs],
   output fvt_pkg::fix_type          bias_o
);
   import fvt_pkg::*;

   plane_type plane_ff [PlaneRegs];
   fix_type   bias_ff;
   idx_type   idx;
   logic      wr;

   assign idx    = paddr[AddrWidth-1:3];
   assign wr     = psel & penable & pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PlaneRegs; i++) begin
            plane_ff[i] <= '0;
         end
         bias_ff <= '0;
      end else if (wr) begin
         if (idx < IdxWidth'(PlaneRegs)) begin
            plane_ff[idx] <= pwdata;
         end else if (idx == RegBias) begin
            bias_ff <= pwdata[15:0];
         end
      end
   end

   always_comb begin
      prdata = '0;
      if (idx < IdxWidth'(PlaneRegs)) begin
         prdata = plane_ff[idx];
      end else if (idx == RegBias) begin
         prdata = {48'b0, bias_ff};
      end
   end

   assign plane_o = plane_ff;
   assign bias_o  = bias_ff;
endmodule

// ===== design/fvt_plane.sv =====
// One plane test: registered products, then exact sum and compare to the bias.
module fvt_plane (
   input  logic               clock,
   input  logic               load,
   input  fvt_pkg::plane_type plane,
   input  fvt_pkg::fix_type   pos_x,
   input  fvt_pkg::fix_type   pos_y,
   input  fvt_pkg::fix_type   pos_z,
   input  fvt_pkg::radius_type radius,
   input  fvt_pkg::fix_type   bias,
   output logic               hit
);
   import fvt_pkg::*;

   prod_type px_ff, py_ff, pz_ff;
   ofs_type  ofs_ff;
   sum_type  sum, thr;

   always_ff @(posedge clock) begin
      if (load) begin
         px_ff  <= plane.nx * pos_x;
         py_ff  <= plane.ny * pos_y;
         pz_ff  <= plane.nz * pos_z;
         ofs_ff <= ofs_type'(plane.offset) + $signed({2'b0, radius});
      end
   end

   // offset, radius and bias are Q11.4, scaled up to the Q.18 of the products
   always_comb begin
      sum = sum_type'(px_ff) + sum_type'(py_ff) + sum_type'(pz_ff)
          + (sum_type'(ofs_ff) <<< ScaleShift);
      thr = sum_type'(bias) <<< ScaleShift;
      hit = (sum >= thr);
   end
endmodule

// ===== design/frustum_visibility_test.sv =====
// Top level of the six-plane frustum visibility test.
//
//   channel  | dir | handshake            | payload
//   req_ch   | in  | valid/ready          | pos_x, pos_y, pos_z, radius, last_vertex
//   rsp_ch   | out | valid/ready          | visible (one per last_vertex item)
//   csr_*    | in  | APB psel/penable     | plane_0..plane_5 at 8*i, cull_bias at 0x30
//
// One item per cycle unless a last item stalls; products are registered at accept, and
// the flags and the result register update as the item leaves the product stage.
// Synchronous active-high reset clears flags and valid state; planes and bias reset to 0.
// A last item waits in the product stage only while an unread result blocks the output.
module frustum_visibility_test #(
   parameter int NUM_PLANES = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   fvt_req_if.sink                       req_ch,
   fvt_rsp_if.source                     rsp_ch,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [fvt_pkg::AddrWidth-1:0] csr_paddr,
   input  fvt_pkg::data_type             csr_pwdata,
   output fvt_pkg::data_type             csr_prdata,
   output logic                          csr_pready
);
   import fvt_pkg::*;

   plane_type planes [PlaneRegs];
   fix_type   bias;

   logic a_vld_ff, a_vld_in;
   logic a_last_ff;
   logic [NUM_PLANES-1:0] flags_ff, flags_in;
   logic [NUM_PLANES-1:0] hit, seen;
   logic rsp_vld_ff, rsp_vld_in;
   logic visible_ff, visible_in;
   logic accept, a_go, out_free;

   fvt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .plane_o (planes),
      .bias_o  (bias)
   );

   for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
      plane_type coef;
      if (p < PlaneRegs) begin : g_reg
         assign coef = planes[p];
      end else begin : g_zero
         assign coef = '0;
      end
      fvt_plane u_plane (
         .clock  (clock),
         .load   (accept),
         .plane  (coef),
         .pos_x  (req_ch.pos_x),
         .pos_y  (req_ch.pos_y),
         .pos_z  (req_ch.pos_z),
         .radius (req_ch.radius),
         .bias   (bias),
         .hit    (hit[p])
      );
   end

   assign out_free     = !rsp_vld_ff || rsp_ch.ready;
   assign a_go         = a_vld_ff && (!a_last_ff || out_free);
   assign req_ch.ready = !a_vld_ff || a_go;
   assign accept       = req_ch.valid && req_ch.ready;
   assign seen         = flags_ff | hit;

   always_comb begin
      a_vld_in = a_vld_ff;
      if (accept) begin
         a_vld_in = 1'b1;
      end else if (a_go) begin
         a_vld_in = 1'b0;
      end

      flags_in = flags_ff;
      if (a_go) begin
         flags_in = a_last_ff ? '0 : seen;
      end

      rsp_vld_in = rsp_vld_ff;
      visible_in = visible_ff;
      if (a_go && a_last_ff) begin
         rsp_vld_in = 1'b1;
         visible_in = &seen;
      end else if (rsp_ch.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff   <= 1'b0;
         flags_ff   <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         a_vld_ff   <= a_vld_in;
         flags_ff   <= flags_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_last_ff <= req_ch.last_vertex;
      end
      visible_ff <= visible_in;
   end

   assign rsp_ch.valid   = rsp_vld_ff;
   assign rsp_ch.visible = visible_ff;
endmodule
